>>> design/pns_pkg.sv
// phone number spotter: shared types, character codes and the csr map
// no dependencies; imported by every design file of the block

package pns_pkg;

   // input transfer: one text byte and the end-of-text flag
   typedef struct packed {
      logic [7:0] text_char;
      logic       last;
   } pns_req_type;

   // result transfer: start offset and length of the spotted number
   typedef struct packed {
      logic        found;
      logic [11:0] start_offset;
      logic [7:0]  number_length;
   } pns_rsp_type;

   // scanner to output buffer
   typedef struct packed {
      logic        valid;
      pns_rsp_type data;
   } pns_result_type;

   localparam int OFS_W = 12;
   localparam int LEN_W = 8;
   localparam int RUN_W = 9;               // run count saturates at 256

   localparam logic [RUN_W-1:0] RUN_SAT = 9'd256;
   localparam logic [7:0] MIN_PASS_LEN = 8'd5;
   localparam logic [7:0] MAX_LENGTH_RESET = 8'd64;

   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_HASH   = 8'h23;

   // csr map: byte address 4*i, paddr[2] selects the register slot
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_MAX_LENGTH = 1'b0;

   function automatic logic is_number_char(input logic [7:0] c);
      logic hit;
      unique case (c) inside
         [CH_ZERO:CH_NINE], CH_DASH, CH_AT, CH_COMMA,
         CH_LPAREN, CH_RPAREN, CH_STAR, CH_HASH: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

>>> design/pns_csr.sv
// phone number spotter: apb-style register file holding max_length
// depends on pns_pkg

module pns_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pns_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output logic [7:0]                     max_length
);
   import pns_pkg::*;

   logic [7:0] max_length_ff;
   logic [7:0] max_length_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_length_in = max_length_ff;
      if (wr_en && (csr_paddr[2] == REG_MAX_LENGTH)) begin
         max_length_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MAX_LENGTH: csr_prdata = {24'd0, max_length_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign max_length = max_length_ff;

endmodule

>>> design/pns_scan.sv
// phone number spotter: run tracking state and the window pass decision
// depends on pns_pkg; feeds pns_out_buf

module pns_scan #(
   parameter int MAX_TEXT = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  pns_pkg::pns_req_type    req,
   input  logic [7:0]              max_length,
   output pns_pkg::pns_result_type result
);
   import pns_pkg::*;

   localparam int POS_W = $clog2(MAX_TEXT);
   localparam int CNT_W = $clog2(MAX_TEXT + 1);
   localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam logic [CNT_W-1:0] TEXT_END = CNT_W'(MAX_TEXT);

   logic [CNT_W-1:0] char_position_ff, char_position_in;
   logic [POS_W-1:0] window_start_ff, window_start_in;
   logic [POS_W-1:0] dash_position_ff, dash_position_in;
   logic [RUN_W-1:0] run_count_ff, run_count_in;
   logic             dash_seen_ff, dash_seen_in;
   logic             already_reported_ff, already_reported_in;

   logic             pos_ok;
   logic [POS_W-1:0] pos;
   logic             num_char;
   logic             j_closed;
   logic [RUN_W-1:0] j_run;
   logic [POS_W-1:0] j_start;
   logic [POS_W-1:0] j_dash;
   logic             j_dash_seen;
   logic             hit;
   logic [POS_W-1:0] hit_start;
   logic [LEN_W-1:0] hit_len;
   logic [CMP_W-1:0] dash_dist;
   logic [CMP_W-1:0] early_start;
   logic [POS_W+OFS_W-1:0] start_wide;

   assign pos_ok   = char_position_ff < TEXT_END;
   assign pos      = char_position_ff[POS_W-1:0];
   assign num_char = pos_ok && is_number_char(req.text_char);

   // window view after this byte: a number byte extends the run,
   // anything else closes the run as it stands
   always_comb begin
      j_closed    = 1'b1;
      j_run       = run_count_ff;
      j_start     = window_start_ff;
      j_dash      = dash_position_ff;
      j_dash_seen = dash_seen_ff;
      if (num_char) begin
         j_closed = req.last;
         j_run    = (run_count_ff == RUN_SAT) ? run_count_ff : run_count_ff + 1'b1;
         if (run_count_ff == '0) begin
            j_start     = pos;
            j_dash      = '0;
            j_dash_seen = 1'b0;
         end
         if ((req.text_char == CH_DASH) && !j_dash_seen) begin
            j_dash_seen = 1'b1;
            j_dash      = pos;
         end
      end
   end

   assign dash_dist   = CMP_W'(j_dash - j_start);
   // dash lies beyond the cap: the window ending at the dash wins
   assign early_start = CMP_W'(j_dash) - CMP_W'(max_length) + 1'b1;

   always_comb begin
      hit       = 1'b0;
      hit_start = j_start;
      hit_len   = max_length;
      if (j_dash_seen && (max_length > MIN_PASS_LEN) && (j_run != '0)) begin
         if (dash_dist < CMP_W'(max_length)) begin
            if (j_run >= {1'b0, max_length}) begin
               hit = 1'b1;
            end else if (j_closed && (j_run > RUN_W'(MIN_PASS_LEN))) begin
               hit     = 1'b1;
               hit_len = j_run[LEN_W-1:0];
            end
         end else begin
            hit       = 1'b1;
            hit_start = early_start[POS_W-1:0];
         end
      end
   end

   assign start_wide = {{OFS_W{1'b0}}, hit_start};

   always_comb begin
      char_position_in    = char_position_ff;
      window_start_in     = window_start_ff;
      dash_position_in    = dash_position_ff;
      run_count_in        = run_count_ff;
      dash_seen_in        = dash_seen_ff;
      already_reported_in = already_reported_ff;
      result              = '0;
      if (accept) begin
         if (!already_reported_ff) begin
            if (num_char) begin
               window_start_in  = j_start;
               dash_position_in = j_dash;
               dash_seen_in     = j_dash_seen;
               run_count_in     = j_run;
            end else begin
               run_count_in = '0;
               dash_seen_in = 1'b0;
            end
            if (pos_ok) begin
               char_position_in = char_position_ff + 1'b1;
            end
            if (hit) begin
               already_reported_in        = 1'b1;
               result.valid               = 1'b1;
               result.data.found          = 1'b1;
               result.data.start_offset   = start_wide[OFS_W-1:0];
               result.data.number_length  = hit_len;
            end else if (req.last) begin
               result.valid = 1'b1;
            end
         end
         if (req.last) begin
            char_position_in    = '0;
            window_start_in     = '0;
            dash_position_in    = '0;
            run_count_in        = '0;
            dash_seen_in        = 1'b0;
            already_reported_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_position_ff    <= '0;
         window_start_ff     <= '0;
         dash_position_ff    <= '0;
         run_count_ff        <= '0;
         dash_seen_ff        <= 1'b0;
         already_reported_ff <= 1'b0;
      end else begin
         char_position_ff    <= char_position_in;
         window_start_ff     <= window_start_in;
         dash_position_ff    <= dash_position_in;
         run_count_ff        <= run_count_in;
         dash_seen_ff        <= dash_seen_in;
         already_reported_ff <= already_reported_in;
      end
   end

endmodule

>>> design/pns_out_buf.sv
// phone number spotter: result register with a skid slot
// depends on pns_pkg; the input stall comes straight from the skid flag

module pns_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  pns_pkg::pns_result_type result,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output pns_pkg::pns_rsp_type    rsp_data,
   output logic                    req_stall
);
   import pns_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   pns_rsp_type out_data_ff, out_data_in;
   pns_rsp_type skid_data_ff, skid_data_in;
   logic        drain;

   assign drain = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no new result can arrive while the input is stalled
         if (drain) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result.valid) begin
         if (!out_valid_ff || drain) begin
            out_valid_in = 1'b1;
            out_data_in  = result.data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result.data;
         end
      end else if (drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign req_stall = skid_valid_ff;

endmodule

>>> design/phone_number_spotter_top.sv
// Phone number spotter. Takes one text byte per clock and reports, once per
// text, the earliest start of a run of number characters that is longer than
// five and holds a dash (capped at max_length), or found = 0 on the last byte.
// Throughput is one byte per cycle while req_stall is low. The decision is made
// when the byte is taken; the result is registered in one of the two slots of
// the result buffer, which lets input continue while a result waits; req_stall
// rises only when both slots are full. max_length sits at csr address 0.
// depends on pns_pkg, pns_csr, pns_scan, pns_out_buf

module phone_number_spotter_top #(
   parameter int MAX_TEXT = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pns_pkg::pns_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pns_pkg::pns_rsp_type           rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pns_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import pns_pkg::*;

   logic           accept;
   logic [7:0]     max_length;
   pns_result_type result;

   assign accept = req_valid && !req_stall;

   pns_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_length  (max_length)
   );

   pns_scan #(
      .MAX_TEXT (MAX_TEXT)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .max_length (max_length),
      .result     (result)
   );

   pns_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .req_stall (req_stall)
   );

endmodule

>>> design/pns_checker.sv
// phone number spotter: port-level checks, bound to the top level
// depends on pns_pkg and phone_number_spotter_top

module pns_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input pns_pkg::pns_rsp_type rsp_data
);
   import pns_pkg::*;

   // reset empties both result slots
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result buffer not empty after reset");

   // input only backs up when a result is held
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // a not-found transfer carries zero offset and length
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.start_offset == '0 && rsp_data.number_length == '0)
      else $error("not-found result with nonzero fields");

   // a spotted number is always longer than the minimum
   a_hit_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.number_length > MIN_PASS_LEN)
      else $error("found result too short");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind phone_number_spotter_top pns_checker u_pns_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> bench/tb_phone_number_spotter_top.sv
// self-checking bench for phone_number_spotter_top: texts go in as byte transfers,
// results are predicted per accepted byte and checked in order, max_length swept over apb
// depends on pns_pkg and the design files of the block

module tb_phone_number_spotter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pns_pkg::*;

   localparam int TEXT_LIMIT = 4096;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 180;
   localparam int NUM_PHASES = 9;
   localparam int SHOWN_ERRORS = 10;
   localparam logic [CSR_ADDR_W-1:0] MAX_LENGTH_ADDR = {REG_MAX_LENGTH, 2'b00};

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   pns_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pns_rsp_type rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   phone_number_spotter_top #(.MAX_TEXT(TEXT_LIMIT)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout: run did not complete");
      $display("CHECKS FAILED");
      $finish;
   end

   // scanner copy kept by the bench
   int unsigned cap_len = MAX_LENGTH_RESET;
   int unsigned text_pos, run_begin, run_dash_pos, run_chars;
   bit          run_has_dash, text_done;

   pns_req_type char_feed[$];
   pns_rsp_type spotted_q[$];
   logic [7:0]  text_buf[$];

   int unsigned error_count, results_checked, numbers_found, texts_queued, settings_used;
   bit          req_fire = 1'b0;

   function automatic bit number_char(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || c == CH_DASH || c == CH_AT || c == CH_COMMA ||
             c == CH_LPAREN || c == CH_RPAREN || c == CH_STAR || c == CH_HASH;
   endfunction

   function automatic void clear_scan();
      text_pos = 0;
      run_begin = 0;
      run_dash_pos = 0;
      run_chars = 0;
      run_has_dash = 0;
      text_done = 0;
   endfunction

   // decides whether the current run yields the earliest passing window
   function automatic bit run_passes(input bit closed, output int unsigned s,
                                     output int unsigned n);
      s = 0;
      n = 0;
      if (!run_has_dash || cap_len <= MIN_PASS_LEN || run_chars == 0) return 0;
      if (run_dash_pos - run_begin < cap_len) begin
         if (run_chars >= cap_len) begin
            s = run_begin;
            n = cap_len;
            return 1;
         end
         if (closed && run_chars > MIN_PASS_LEN) begin
            s = run_begin;
            n = run_chars;
            return 1;
         end
         return 0;
      end
      // first dash lies past the cap: window ends on the dash
      s = run_dash_pos - cap_len + 1;
      n = cap_len;
      return 1;
   endfunction

   function automatic bit predict_char(input pns_req_type r, output pns_rsp_type res);
      int unsigned s, n;
      bit hit, in_run;
      hit = 0;
      res = '0;
      if (!text_done) begin
         in_run = (text_pos < TEXT_LIMIT) && number_char(r.text_char);
         if (in_run) begin
            if (run_chars == 0) begin
               run_begin = text_pos;
               run_has_dash = 0;
               run_dash_pos = 0;
            end
            run_chars++;
            if (r.text_char == CH_DASH && !run_has_dash) begin
               run_has_dash = 1;
               run_dash_pos = text_pos;
            end
            hit = run_passes(r.last, s, n);
         end else begin
            hit = run_passes(1'b1, s, n);
            run_chars = 0;
            run_has_dash = 0;
         end
         if (hit) begin
            res.found = 1'b1;
            res.start_offset = s[11:0];
            res.number_length = n[7:0];
            text_done = 1;
         end
         if (text_pos < TEXT_LIMIT) text_pos++;
         if (r.last && !hit) begin
            res = '0;
            hit = 1;
         end
      end
      if (r.last) clear_scan();
      return hit;
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= SHOWN_ERRORS) $display("ERROR: %s", msg);
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (number_char(c));
      return c;
   endfunction

   function automatic logic [7:0] digit_char();
      int unsigned sel;
      sel = $urandom_range(0, 15);
      if (sel < 10) return CH_ZERO + 8'(sel);
      case (sel)
         10: return CH_AT;
         11: return CH_COMMA;
         12: return CH_LPAREN;
         13: return CH_RPAREN;
         14: return CH_STAR;
         default: return CH_HASH;
      endcase
   endfunction

   function automatic void add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   function automatic void flush_text();
      pns_req_type r;
      foreach (text_buf[i]) begin
         r.text_char = text_buf[i];
         r.last = (i == text_buf.size() - 1);
         char_feed.push_back(r);
      end
      text_buf.delete();
      texts_queued++;
   endfunction

   function automatic int unsigned pick_run_len(input int unsigned c);
      if (c > 12 && $urandom_range(0, 3) == 0) return $urandom_range(1, c + 3);
      return $urandom_range(1, 14);
   endfunction

   function automatic void build_text();
      int unsigned kind, c, runs, run_n, d1, d2;
      c = cap_len;
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
         repeat ($urandom_range(1, 24)) text_buf.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 5 && c > 0 && c <= 64) begin
         // run whose first dash sits at or past the cap
         repeat ($urandom_range(0, 3)) text_buf.push_back(noise_char());
         run_n = c + $urandom_range(1, 10);
         d1 = $urandom_range(c, run_n - 1);
         for (int i = 0; i < run_n; i++) text_buf.push_back(i == d1 ? CH_DASH : digit_char());
         repeat ($urandom_range(0, 2)) text_buf.push_back(noise_char());
      end else begin
         runs = $urandom_range(1, 3);
         repeat (runs) begin
            repeat ($urandom_range(0, 4)) text_buf.push_back(noise_char());
            run_n = pick_run_len(c);
            d1 = (kind < 7) ? run_n : $urandom_range(0, run_n - 1);
            d2 = ($urandom_range(0, 2) == 0) ? $urandom_range(0, run_n - 1) : run_n;
            for (int i = 0; i < run_n; i++)
               text_buf.push_back((i == d1 || i == d2) ? CH_DASH : digit_char());
         end
         // otherwise the final byte lands inside a run
         if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 3)) text_buf.push_back(noise_char());
      end
      flush_text();
   endfunction

   // ---------------- driver and receiver ----------------

   int unsigned gap_left = 0, burst_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // transfer still pending, hold payload
      end else if (gap_left != 0 || char_feed.size() == 0) begin
         req_valid <= 1'b0;
         if (gap_left != 0) gap_left--;
      end else begin
         req_valid <= 1'b1;
         req_data <= char_feed.pop_front();
         if (burst_left <= 1) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
         end else begin
            burst_left--;
         end
      end
   end

   stall_mode_type stall_mode = STALL_NONE;
   int unsigned mode_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((mode_left % 9) < 5);
         endcase
      end
   end

   // ---------------- monitor and checker ----------------

   always @(posedge clock) begin
      pns_rsp_type want, got;
      bit made;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         // check before predicting so a new expectation never meets an older result
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (spotted_q.size() == 0) begin
               flag_error($sformatf("result with nothing expected: found=%0b offset=%0d len=%0d",
                                    got.found, got.start_offset, got.number_length));
            end else begin
               want = spotted_q.pop_front();
               if (got.found !== want.found || got.start_offset !== want.start_offset ||
                   got.number_length !== want.number_length)
                  flag_error($sformatf({"result %0d: expected found=%0b offset=%0d len=%0d,",
                                        " got found=%0b offset=%0d len=%0d"},
                                       results_checked, want.found, want.start_offset,
                                       want.number_length, got.found, got.start_offset,
                                       got.number_length));
               results_checked++;
               if (want.found) numbers_found++;
            end
         end
         if (req_valid && !req_stall) begin
            made = predict_char(req_data, want);
            if (made) spotted_q.push_back(want);
         end
      end
   end

   // ---------------- register access and sequencing ----------------

   task automatic csr_access(input bit wr, input logic [7:0] value, output logic [31:0] rd);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= MAX_LENGTH_ADDR;
      csr_pwdata <= {24'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_max_length(input logic [7:0] value);
      logic [31:0] rd;
      csr_access(1'b0, 8'd0, rd);
      if (rd !== {24'd0, value})
         flag_error($sformatf("max_length read back %0h, expected %0h", rd, value));
   endtask

   task automatic set_max_length(input logic [7:0] value);
      logic [31:0] rd;
      csr_access(1'b1, value, rd);
      cap_len = value;
      settings_used++;
      check_max_length(value);
   endtask

   task automatic drain();
      while (char_feed.size() != 0 || req_valid || spotted_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned caps[NUM_PHASES];
      int unsigned goal;
      caps = '{64, 6, 0, 255, 5, 7, 12, 0, 64};
      caps[7] = $urandom_range(13, 50);
      clear_scan();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_max_length(MAX_LENGTH_RESET);
      settings_used = 1;

      // directed: number closed by the final byte, number closed by a letter then
      // ignored bytes, extreme byte values, a dashed run that is one too short
      add_str("a(12)-34#");
      flush_text();
      add_str("12-4,6x*@");
      flush_text();
      text_buf.push_back(8'hFF);
      text_buf.push_back(8'h00);
      flush_text();
      add_str("--09-");
      flush_text();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) set_max_length(caps[ph][7:0]);
         goal = char_feed.size() + PHASE_ITEMS;
         while (char_feed.size() < goal) build_text();
         drain();
      end

      if (spotted_q.size() != 0)
         flag_error($sformatf("%0d expected results never arrived", spotted_q.size()));

      $display("covered %0d texts over %0d max_length settings", texts_queued, settings_used);
      $display("checked %0d results, %0d of them spotted numbers, %0d errors",
               results_checked, numbers_found, error_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
